/* design/assert_macros.svh */
// Shared assertion macros. Each macro checks an implication on the rising
// clock edge and is disabled while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DFD_ASSERT_IMP(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication.
`define DFD_ASSERT_NXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (ante) |=> (cons)) else $error("assertion failed");

`else

`define DFD_ASSERT_IMP(label, clock, resetn, ante, cons)
`define DFD_ASSERT_NXT(label, clock, resetn, ante, cons)

`endif

`endif

/* design/dfd_pkg.sv */
package dfd_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 2048;
    localparam int LEN_W = 12;
    localparam int LEN_MAX = 4095;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam logic [1:0] CFG_FLAG  = 2'd0;
    localparam logic [1:0] CFG_OPEN  = 2'd1;
    localparam logic [1:0] CFG_CLOSE = 2'd2;
    localparam logic [1:0] CFG_MAXLEN = 2'd3;

    // End report status codes.
    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_LINK_CLOSED = 2'd2;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             frame_end;
        logic [1:0]       end_status;
        logic [LEN_W-1:0] frame_length;
    } result_t;

    // Results written into the queue by one item: up to two, in order.
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic has_room;
        logic not_empty;
    } qstat_t;

endpackage

/* design/dfd_result_queue.sv */
module dfd_result_queue
    import dfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output result_t head,
    output qstat_t  stat
);

    result_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic [QPTR_W-1:0]  wr_ptr_p1;
    logic               do_pop;

    assign wr_ptr_p1 = wr_ptr_reg + QPTR_W'(1);
    assign do_pop = pop && (count_reg != '0);

    assign wr_ptr_next = wr_ptr_reg + QPTR_W'(push.num);
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(do_pop);
    assign count_next = count_reg + QCNT_W'(push.num) - QCNT_W'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= push.second;
        end
    end

    assign head = mem_reg[rd_ptr_reg];

    // Room for the worst case of two results from the next item.
    assign stat.has_room = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign stat.not_empty = (count_reg != '0);

endmodule

/* design/delimited_frame_deframer_core.sv */
// Channel   Direction  Signals
// -------   ---------  ---------------------------------------------------
// in        sink       in_valid, in_ready, rx_byte, link_closed
// out       source     out_valid, out_ready, data_byte, frame_end,
//                      end_status, frame_length
// cfg       sink       cfg_valid, cfg_ready, cfg_index, cfg_data
//
// The parser decodes an item in the cycle it is accepted and writes zero,
// one or two results into a four-entry result queue; results leave one per
// cycle while out_ready is high, a rate set by the queue's single read port.
// A new item can be taken while earlier results still wait in the queue.
// in_ready drops only while the queue lacks room for two results.
// Reset restores the default marks and length limit and hunts for a flag.
// cfg_ready is always high.
`include "assert_macros.svh"

module delimited_frame_deframer_core
    import dfd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic             link_closed,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       data_byte,
    output logic             frame_end,
    output logic [1:0]       end_status,
    output logic [LEN_W-1:0] frame_length,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [LEN_W-1:0] cfg_data
);

    localparam int CAP_INT = (MAX_FRAME_BYTES > LEN_MAX) ? LEN_MAX : MAX_FRAME_BYTES;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

    localparam logic [1:0] PH_HUNT1 = 2'd0;
    localparam logic [1:0] PH_HUNT2 = 2'd1;
    localparam logic [1:0] PH_RECV  = 2'd2;
    localparam logic [1:0] PH_STOP1 = 2'd3;

    logic [7:0]       flag_char_reg;
    logic [7:0]       open_char_reg;
    logic [7:0]       close_char_reg;
    logic [LEN_W-1:0] max_len_reg;

    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] count_p1;
    logic             fit1, fit2;
    logic             accept;
    push_t            push;
    result_t          head;
    qstat_t           qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_char_reg <= 8'd33;
            open_char_reg <= 8'd38;
            close_char_reg <= 8'd35;
            max_len_reg <= LEN_W'(2048);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FLAG:   flag_char_reg <= cfg_data[7:0];
                CFG_OPEN:   open_char_reg <= cfg_data[7:0];
                CFG_CLOSE:  close_char_reg <= cfg_data[7:0];
                CFG_MAXLEN: max_len_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign limit = (max_len_reg > LEN_CAP) ? LEN_CAP : max_len_reg;
    assign count_p1 = count_reg + LEN_W'(1);
    assign fit1 = (count_reg < limit);
    // Only meaningful when fit1 holds, so count_p1 cannot wrap.
    assign fit2 = fit1 && (count_p1 < limit);

    assign accept = in_valid && in_ready;
    assign in_ready = qstat.has_room;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        push = '0;
        if (accept)
        begin
            if (link_closed)
            begin
                if (phase_reg == PH_RECV || phase_reg == PH_STOP1)
                begin
                    push.num = 2'd1;
                    push.first.frame_end = 1'b1;
                    push.first.end_status = ST_LINK_CLOSED;
                    push.first.frame_length = count_reg;
                end
                phase_next = PH_HUNT1;
                count_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT1:
                    begin
                        if (rx_byte == flag_char_reg)
                        begin
                            phase_next = PH_HUNT2;
                        end
                    end
                    PH_HUNT2:
                    begin
                        if (rx_byte == open_char_reg)
                        begin
                            phase_next = PH_RECV;
                            count_next = '0;
                            ovf_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = PH_HUNT1;
                        end
                    end
                    PH_RECV:
                    begin
                        if (rx_byte == flag_char_reg)
                        begin
                            phase_next = PH_STOP1;
                        end
                        else if (fit1)
                        begin
                            push.num = 2'd1;
                            push.first.data_byte = rx_byte;
                            count_next = count_p1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    PH_STOP1:
                    begin
                        if (rx_byte == close_char_reg)
                        begin
                            push.num = 2'd1;
                            push.first.frame_end = 1'b1;
                            push.first.end_status = ovf_reg ? ST_OVERFLOW : ST_COMPLETE;
                            push.first.frame_length = count_reg;
                            phase_next = PH_HUNT1;
                            count_next = '0;
                            ovf_next = 1'b0;
                        end
                        else
                        begin
                            // The held flag goes out first, then this byte, as far as the length limit allows.
                            phase_next = PH_RECV;
                            push.first.data_byte = flag_char_reg;
                            push.second.data_byte = rx_byte;
                            if (fit2)
                            begin
                                push.num = 2'd2;
                                count_next = count_p1 + LEN_W'(1);
                            end
                            else if (fit1)
                            begin
                                push.num = 2'd1;
                                count_next = count_p1;
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            count_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
        end
    end

    dfd_result_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_ready),
        .head  (head),
        .stat  (qstat)
    );

    assign out_valid = qstat.not_empty;
    assign data_byte = head.data_byte;
    assign frame_end = head.frame_end;
    assign end_status = head.end_status;
    assign frame_length = head.frame_length;

    `DFD_ASSERT_IMP(a_hunt_no_result, clk, rst_n,
        accept && (phase_reg == PH_HUNT1 || phase_reg == PH_HUNT2), push.num == 2'd0)
    `DFD_ASSERT_IMP(a_count_capped, clk, rst_n, 1'b1, count_reg <= LEN_CAP)
    `DFD_ASSERT_NXT(a_close_rehunts, clk, rst_n, accept && link_closed,
        phase_reg == PH_HUNT1 && count_reg == '0 && !ovf_reg)
    `DFD_ASSERT_IMP(a_end_zero_data, clk, rst_n, out_valid && frame_end, data_byte == 8'd0)

endmodule

/* sim/tb_delimited_frame_deframer_core.sv */
module tb_delimited_frame_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dfd_pkg::*;

    localparam int FRAME_CAP = DEFAULT_MAX_FRAME_BYTES;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_DIR_ROWS = 25;
    localparam int NUM_PHASES = 7;

    // Default marks.
    localparam logic [7:0] CH_FLAG  = 8'h21;
    localparam logic [7:0] CH_OPEN  = 8'h26;
    localparam logic [7:0] CH_CLOSE = 8'h23;

    localparam result_t NO_RES = '0;

    typedef enum logic [1:0] {HUNT_FLAG, HUNT_OPEN, IN_PAYLOAD, FLAG_SEEN} parse_phase_e;
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e   kind;
        logic [11:0] value;
        logic        lc;
        logic        typed;
        logic [1:0]  n_typed;
        result_t     r0;
        result_t     r1;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] b;
        logic       lc;
    } stim_t;

    typedef struct {
        logic [7:0]  flag_ch;
        logic [7:0]  open_ch;
        logic [7:0]  close_ch;
        logic [11:0] maxlen;
        int          send_idle;
        int          stall;
        int          items;
        bit          rand_marks;
        bit          hold_off;
        bit          mid_pause;
    } phase_cfg_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [7:0]       rx_byte;
    logic             link_closed;
    logic             out_valid;
    logic             out_ready;
    logic [7:0]       data_byte;
    logic             frame_end;
    logic [1:0]       end_status;
    logic [LEN_W-1:0] frame_length;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [LEN_W-1:0] cfg_data;

    // Deframer shadow state and register copies.
    logic [7:0]       cfg_flag;
    logic [7:0]       cfg_open;
    logic [7:0]       cfg_close;
    logic [11:0]      cfg_maxlen;
    parse_phase_e     phase;
    logic [11:0]      kept_count;
    logic             overflow_seen;

    result_t          step_results[$];
    result_t          deframed_q[$];
    stim_t            stim_q[$];

    dir_row_t         dir_rows [NUM_DIR_ROWS];
    phase_cfg_t       phases [NUM_PHASES];

    int send_idle_pct;
    int stall_pct;
    int hold_off_cycles;
    int errors;
    int items_sent;
    int results_seen;
    int ends_complete;
    int ends_overflow;
    int ends_closed;

    delimited_frame_deframer_core #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .link_closed(link_closed),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .data_byte(data_byte),
        .frame_end(frame_end),
        .end_status(end_status),
        .frame_length(frame_length),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic result_t payload_res(input logic [7:0] b);
        result_t r;
        r = '0;
        r.data_byte = b;
        return r;
    endfunction

    function automatic result_t end_report(input logic [1:0] status, input logic [11:0] len);
        result_t r;
        r = '0;
        r.frame_end = 1'b1;
        r.end_status = status;
        r.frame_length = len;
        return r;
    endfunction

    function automatic int unsigned frame_limit();
        return (cfg_maxlen > FRAME_CAP) ? FRAME_CAP : cfg_maxlen;
    endfunction

    function automatic void keep_payload(input logic [7:0] b);
        if (kept_count < frame_limit())
        begin
            step_results.push_back(payload_res(b));
            kept_count = kept_count + 12'd1;
        end
        else
        begin
            overflow_seen = 1'b1;
        end
    endfunction

    // Advances the shadow parser by one item and leaves its results in step_results.
    function automatic void deframe_byte(input logic [7:0] b, input logic lc);
        step_results.delete();
        if (lc)
        begin
            if (phase == IN_PAYLOAD || phase == FLAG_SEEN)
                step_results.push_back(end_report(ST_LINK_CLOSED, kept_count));
            phase = HUNT_FLAG;
            kept_count = '0;
            overflow_seen = 1'b0;
        end
        else
        begin
            case (phase)
                HUNT_FLAG:
                begin
                    if (b == cfg_flag)
                        phase = HUNT_OPEN;
                end
                HUNT_OPEN:
                begin
                    if (b == cfg_open)
                    begin
                        phase = IN_PAYLOAD;
                        kept_count = '0;
                        overflow_seen = 1'b0;
                    end
                    else
                    begin
                        phase = HUNT_FLAG;
                    end
                end
                IN_PAYLOAD:
                begin
                    if (b == cfg_flag)
                        phase = FLAG_SEEN;
                    else
                        keep_payload(b);
                end
                default:
                begin
                    if (b == cfg_close)
                    begin
                        step_results.push_back(end_report(
                            overflow_seen ? ST_OVERFLOW : ST_COMPLETE, kept_count));
                        phase = HUNT_FLAG;
                        kept_count = '0;
                        overflow_seen = 1'b0;
                    end
                    else
                    begin
                        // An escaped pair keeps the flag first; the second byte may not fit.
                        keep_payload(cfg_flag);
                        keep_payload(b);
                        phase = IN_PAYLOAD;
                    end
                end
            endcase
        end
    endfunction

    // Queues one frame with random content, or a short burst of line noise.
    function automatic void queue_frame();
        int unsigned len;
        int unsigned span;
        if ($urandom_range(99) < 75)
        begin
            stim_q.push_back('{cfg_flag, 1'b0});
            stim_q.push_back('{cfg_open, 1'b0});
            span = frame_limit() + 4;
            if (span > 60)
                span = 60;
            len = ($urandom_range(7) == 0) ? $urandom_range(span) : $urandom_range(12);
            repeat (len)
            begin
                if ($urandom_range(9) == 0)
                    stim_q.push_back('{cfg_flag, 1'b0});
                stim_q.push_back('{8'($urandom_range(255)), 1'b0});
            end
            if ($urandom_range(99) < 85)
            begin
                stim_q.push_back('{cfg_flag, 1'b0});
                stim_q.push_back('{cfg_close, 1'b0});
            end
            else
            begin
                stim_q.push_back('{8'($urandom_range(255)), 1'b1});
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(9))
                    0:       stim_q.push_back('{8'($urandom_range(255)), 1'b1});
                    1, 2:    stim_q.push_back('{cfg_flag, 1'b0});
                    3:       stim_q.push_back('{cfg_open, 1'b0});
                    default: stim_q.push_back('{8'($urandom_range(255)), 1'b0});
                endcase
            end
        end
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_item(input logic [7:0] b, input logic lc, input logic typed,
                             input logic [1:0] n_typed, input result_t r0, input result_t r1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        link_closed = lc;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_byte(b, lc);
        if (typed)
        begin
            if (n_typed > 0)
                deframed_q.push_back(r0);
            if (n_typed > 1)
                deframed_q.push_back(r1);
        end
        else
        begin
            foreach (step_results[i])
                deframed_q.push_back(step_results[i]);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (deframed_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_FLAG:  cfg_flag = value[7:0];
            CFG_OPEN:  cfg_open = value[7:0];
            CFG_CLOSE: cfg_close = value[7:0];
            default:   cfg_maxlen = value;
        endcase
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [7:0] f, input logic [7:0] o, input logic [7:0] c,
                             input logic [11:0] m);
        write_reg(CFG_FLAG, {4'h0, f});
        write_reg(CFG_OPEN, {4'h0, o});
        write_reg(CFG_CLOSE, {4'h0, c});
        write_reg(CFG_MAXLEN, m);
        cfg_valid = 1'b0;
    endtask

    // Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (deframed_q.size() == 0)
            begin
                $error("unexpected result: data_byte %0d frame_end %0d end_status %0d len %0d",
                       data_byte, frame_end, end_status, frame_length);
                errors++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0d, actual %0d", want.data_byte, data_byte);
                    errors++;
                end
                if (frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d, actual %0d", want.frame_end, frame_end);
                    errors++;
                end
                if (end_status !== want.end_status)
                begin
                    $error("end_status: expected %0d, actual %0d", want.end_status, end_status);
                    errors++;
                end
                if (frame_length !== want.frame_length)
                begin
                    $error("frame_length: expected %0d, actual %0d",
                           want.frame_length, frame_length);
                    errors++;
                end
            end
            if (frame_end === 1'b1)
            begin
                case (end_status)
                    ST_COMPLETE: ends_complete++;
                    ST_OVERFLOW: ends_overflow++;
                    default:     ends_closed++;
                endcase
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("tb_delimited_frame_deframer_core: errors");
        $finish;
    end

    initial
    begin
        stim_t s;
        int target;
        logic [7:0] f;
        logic [7:0] o;
        logic [7:0] c;
        logic [11:0] m;

        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        link_closed = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FLAG;
        cfg_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        ends_complete = 0;
        ends_overflow = 0;
        ends_closed = 0;

        cfg_flag = CH_FLAG;
        cfg_open = CH_OPEN;
        cfg_close = CH_CLOSE;
        cfg_maxlen = 12'd2048;
        phase = HUNT_FLAG;
        kept_count = '0;
        overflow_seen = 1'b0;

        // Rows marked typed carry their results; the others go through the shadow parser.
        dir_rows = '{
            '{ROW_ITEM, 12'h0FF,   1'b1, 1'b1, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h026,   1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h000,   1'b0, 1'b1, 2'd1, payload_res(8'h00), NO_RES},
            '{ROW_ITEM, 12'h0FF,   1'b0, 1'b1, 2'd1, payload_res(8'hFF), NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b1, 2'd2, payload_res(CH_FLAG),
                                                     payload_res(CH_FLAG)},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h023,   1'b0, 1'b1, 2'd1, end_report(ST_COMPLETE, 12'd4), NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h026,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h055,   1'b0, 1'b1, 2'd1, payload_res(8'h55), NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h000,   1'b1, 1'b1, 2'd1, end_report(ST_LINK_CLOSED, 12'd1),
                                                     NO_RES},
            '{ROW_CFG,  12'd2,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h026,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h061,   1'b0, 1'b1, 2'd1, payload_res(8'h61), NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b1, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h062,   1'b0, 1'b1, 2'd1, payload_res(CH_FLAG), NO_RES},
            '{ROW_ITEM, 12'h063,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h021,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
            '{ROW_ITEM, 12'h023,   1'b0, 1'b1, 2'd1, end_report(ST_OVERFLOW, 12'd2), NO_RES}
        };

        phases = '{
            '{CH_FLAG, CH_OPEN, CH_CLOSE, 12'd2048, 0,  0,  300, 1'b0, 1'b0, 1'b0},
            '{8'h00,   8'hFF,   8'h80,    12'd1,    62, 0,  250, 1'b0, 1'b0, 1'b0},
            '{8'hFF,   8'h00,   8'h7F,    12'd16,   0,  62, 300, 1'b0, 1'b0, 1'b0},
            '{CH_FLAG, CH_OPEN, CH_CLOSE, 12'd8,    19, 19, 300, 1'b1, 1'b0, 1'b1},
            '{8'h55,   8'h55,   8'h55,    12'd2048, 0,  0,  250, 1'b0, 1'b1, 1'b0},
            '{CH_FLAG, CH_OPEN, CH_CLOSE, 12'd8,    62, 0,  300, 1'b1, 1'b0, 1'b0},
            '{CH_FLAG, CH_OPEN, CH_CLOSE, 12'd8,    0,  62, 250, 1'b1, 1'b0, 1'b0}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 19;
        stall_pct = 19;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                write_cfg(cfg_flag, cfg_open, cfg_close, dir_rows[i].value);
            end
            else
            begin
                send_item(dir_rows[i].value[7:0], dir_rows[i].lc, dir_rows[i].typed,
                          dir_rows[i].n_typed, dir_rows[i].r0, dir_rows[i].r1);
            end
        end

        // The parser is not reset between phases, so new marks can land mid-frame.
        foreach (phases[p])
        begin
            wait_idle();
            f = phases[p].flag_ch;
            o = phases[p].open_ch;
            c = phases[p].close_ch;
            m = phases[p].maxlen;
            if (phases[p].rand_marks)
            begin
                f = 8'($urandom_range(255));
                o = 8'($urandom_range(255));
                c = 8'($urandom_range(255));
                m = 12'($urandom_range(1, 40));
            end
            write_cfg(f, o, c, m);
            send_idle_pct = phases[p].send_idle;
            stall_pct = phases[p].stall;
            if (phases[p].hold_off)
                hold_off_cycles = 300;
            target = items_sent + phases[p].items;
            while (items_sent < target)
            begin
                if (stim_q.size() == 0)
                    queue_frame();
                s = stim_q.pop_front();
                send_item(s.b, s.lc, 1'b0, 2'd0, NO_RES, NO_RES);
                if (phases[p].mid_pause && items_sent == target - phases[p].items / 2)
                    wait_idle();
            end
        end

        in_valid = 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d items over %0d mark and limit settings; checked %0d results.",
                 items_sent, NUM_PHASES + 2, results_seen);
        $display("Frame ends seen: %0d complete, %0d overflowed, %0d link closed.",
                 ends_complete, ends_overflow, ends_closed);
        if (errors == 0)
            $display("tb_delimited_frame_deframer_core: clean");
        else
            $display("tb_delimited_frame_deframer_core: errors");
        $finish;
    end

endmodule
